// File: design/tceg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tceg_pkg
// Shared types and constants for the touch contact event generator.
// ----------------------------------------------------------------------------
package tceg_pkg;

  // Default parameter values
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  // Fallback axis bounds used when a programmed axis is degenerate
  localparam int DEFAULT_MAX_X = 1919;
  localparam int DEFAULT_MAX_Y = 1087;

  // Width of the contact count field
  localparam int COUNT_W = 4;

  // Event kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] EV_DOWN   = 2'd0;
  localparam logic [KIND_W-1:0] EV_MOTION = 2'd1;
  localparam logic [KIND_W-1:0] EV_UP     = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MAX_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MAX_Y = 3'd4;

  // Event request from the controller to the merge stage
  typedef struct packed {
    logic load;   // issue an event this cycle
    logic touch;  // 1: DOWN/MOTION from lane results, 0: UP at last position
  } tceg_ctl_t;

endpackage

// File: design/tceg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tceg_lane
// One axis normaliser: clamps the raw coordinate against the active area and
// divides it into fixed point with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module tceg_lane
  import tceg_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int DEF_HI     = DEFAULT_MAX_X
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] raw,
  input  logic [COORD_BITS-1:0] lo,
  input  logic [COORD_BITS-1:0] hi,
  output logic                  busy,
  output logic [FRAC_BITS:0]    pos
);

  // Working width covers both the programmed bounds and the fallback bound
  localparam int HI_W  = $clog2(DEF_HI + 1);
  localparam int D_W   = (COORD_BITS > HI_W) ? COORD_BITS : HI_W;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [D_W-1:0]   HI_DEF = D_W'(DEF_HI);
  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};

  logic [D_W-1:0]   lo_e;
  logic [D_W-1:0]   hi_e;
  logic [D_W-1:0]   raw_e;
  logic [D_W-1:0]   diff;
  logic [D_W-1:0]   span_in;
  logic [D_W-1:0]   span;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     rem_sh;
  logic             ge;
  logic [D_W-1:0]   rem_next;
  logic [CNT_W-1:0] cnt;

  // Bound selection and first compare
  always_comb begin
    if (hi <= lo) begin
      lo_e = '0;
      hi_e = HI_DEF;
    end else begin
      lo_e = D_W'(lo);
      hi_e = D_W'(hi);
    end
    raw_e   = D_W'(raw);
    diff    = raw_e - lo_e;
    span_in = hi_e - lo_e;
  end

  // One quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, 1'b0};
    ge       = rem_sh >= {1'b0, span};
    rem_next = ge ? D_W'(rem_sh - {1'b0, span}) : rem_sh[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      // below the edge gives 0, at or past the far edge gives 1.0
      if (raw_e <= lo_e) begin
        pos  <= '0;
        busy <= 1'b0;
      end else if (diff >= span_in) begin
        pos  <= ONE;
        busy <= 1'b0;
      end else begin
        pos  <= '0;
        rem  <= diff;
        span <= span_in;
        cnt  <= CNT_W'(FRAC_BITS);
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem  <= rem_next;
      pos  <= {pos[FRAC_BITS-1:0], ge};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  // Partial remainder stays below the divisor
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < span))
    else $error("lane remainder reached divisor");

endmodule

// File: design/tceg_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tceg_merge
// Combines the two lane results into an event, tracks the finger state and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tceg_merge
  import tceg_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  tceg_ctl_t           ctl,
  input  logic [FRAC_BITS:0]  lane_pos_x,
  input  logic [FRAC_BITS:0]  lane_pos_y,
  output logic                finger_down,
  output logic                slot_free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [((2*(FRAC_BITS+1)+1+7)/8)*8-1:0] m_tdata,
  output logic [KIND_W-1:0]   m_tuser
);

  localparam int POS_W  = FRAC_BITS + 1;
  localparam int USED_W = 2 * POS_W + 1;
  localparam int TD_W   = ((USED_W + 7) / 8) * 8;

  logic [POS_W-1:0]  last_x;
  logic [POS_W-1:0]  last_y;
  logic [POS_W-1:0]  ev_x;
  logic [POS_W-1:0]  ev_y;
  logic [KIND_W-1:0] ev_kind;
  logic              ev_press;

  assign slot_free = !m_tvalid || m_tready;

  // Event selection
  always_comb begin
    if (ctl.touch) begin
      ev_kind  = finger_down ? EV_MOTION : EV_DOWN;
      ev_x     = lane_pos_x;
      ev_y     = lane_pos_y;
      ev_press = 1'b1;
    end else begin
      ev_kind  = EV_UP;
      ev_x     = last_x;
      ev_y     = last_y;
      ev_press = 1'b0;
    end
  end

  // Finger state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      finger_down <= 1'b0;
      last_x      <= '0;
      last_y      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (ctl.load) begin
        m_tvalid    <= 1'b1;
        m_tdata     <= TD_W'({ev_press, ev_y, ev_x});
        m_tuser     <= ev_kind;
        finger_down <= ctl.touch;
        if (ctl.touch) begin
          last_x <= lane_pos_x;
          last_y <= lane_pos_y;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A release is only issued for a finger that is down
  a_up_needs_finger: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && !ctl.touch) |-> finger_down)
    else $error("UP issued with no finger down");

  // Output register is never overwritten while holding an untaken result
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> slot_free)
    else $error("event loaded over a pending result");

endmodule

// File: design/touch_contact_event_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_contact_event_generator_core
// Single-finger DOWN / MOTION / UP event generator with per-axis normalising
// lanes.
//
//   channel   dir  handshake                 payload
//   s_*       in   s_tvalid / s_tready       tdata: count, raw_x, raw_y;
//                                            tuser: keyboard_active, sample_ok
//   m_*       out  m_tvalid / m_tready       tdata: pos_x, pos_y, pressure;
//                                            tuser: event_kind
//   cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A touch sample passes from the accepted request through the divide and emit
// states to the output register: the two lanes run their restoring dividers in
// parallel, one quotient bit a cycle, and a lane that clamps skips its divider.
// The sequencer returns to idle as the result is loaded. A release goes from
// idle straight to the emit state; an ignored sample leaves the sequencer idle.
// One request is in flight at a time; s_tready is high only when idle.
// A stalled output holds the pipeline in the emit state until m_tready.
// rst is synchronous; config returns to its documented defaults, no finger.
// ----------------------------------------------------------------------------
module touch_contact_event_generator_core
  import tceg_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  // contact_count [3:0], raw_x, raw_y (COORD_BITS each), zero padding
  input  logic [((COUNT_W+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // keyboard_active [0], sample_ok [1]
  input  logic [1:0]                 s_tuser,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // pos_x, pos_y (FRAC_BITS+1 each), pressure, zero padding
  output logic [((2*(FRAC_BITS+1)+1+7)/8)*8-1:0] m_tdata,
  // event_kind [1:0]
  output logic [KIND_W-1:0]          m_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]      cfg_data
);

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMIT = 2'd2;

  logic [ST_W-1:0]       state;
  logic                  pend_touch;
  logic                  enable;
  logic [COORD_BITS-1:0] area_min_x;
  logic [COORD_BITS-1:0] area_max_x;
  logic [COORD_BITS-1:0] area_min_y;
  logic [COORD_BITS-1:0] area_max_y;

  logic                  accept;
  logic                  kb;
  logic                  touch;
  logic [COORD_BITS-1:0] raw_x;
  logic [COORD_BITS-1:0] raw_y;
  logic                  lane_start;
  logic [1:0]            lane_busy;
  logic [FRAC_BITS:0]    lane_pos_x;
  logic [FRAC_BITS:0]    lane_pos_y;
  logic                  finger_down;
  logic                  slot_free;
  tceg_ctl_t             ctl;

  // Input decode
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign kb         = s_tuser[0];
  assign touch      = s_tuser[1] && (s_tdata[COUNT_W-1:0] != '0);
  assign raw_x      = s_tdata[COUNT_W +: COORD_BITS];
  assign raw_y      = s_tdata[COUNT_W+COORD_BITS +: COORD_BITS];
  assign lane_start = accept && enable && !kb && touch;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      area_min_x <= '0;
      area_max_x <= COORD_BITS'(DEFAULT_MAX_X);
      area_min_y <= '0;
      area_max_y <= COORD_BITS'(DEFAULT_MAX_Y);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:     enable     <= cfg_data[0];
        CFG_AREA_MIN_X: area_min_x <= cfg_data;
        CFG_AREA_MAX_X: area_max_x <= cfg_data;
        CFG_AREA_MIN_Y: area_min_y <= cfg_data;
        CFG_AREA_MAX_Y: area_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_touch <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && enable) begin
            if (kb) begin
              if (finger_down) begin
                pend_touch <= 1'b0;
                state      <= ST_EMIT;
              end
            end else if (touch) begin
              pend_touch <= 1'b1;
              state      <= ST_DIV;
            end else if (finger_down) begin
              pend_touch <= 1'b0;
              state      <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (lane_busy == 2'b00) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ctl.load  = (state == ST_EMIT) && slot_free;
  assign ctl.touch = pend_touch;

  // Normalising lanes
  tceg_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DEF_HI     (DEFAULT_MAX_X)
  ) u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .raw   (raw_x),
    .lo    (area_min_x),
    .hi    (area_max_x),
    .busy  (lane_busy[0]),
    .pos   (lane_pos_x)
  );

  tceg_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DEF_HI     (DEFAULT_MAX_Y)
  ) u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .raw   (raw_y),
    .lo    (area_min_y),
    .hi    (area_max_y),
    .busy  (lane_busy[1]),
    .pos   (lane_pos_y)
  );

  // Event merge and output register
  tceg_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .lane_pos_x  (lane_pos_x),
    .lane_pos_y  (lane_pos_y),
    .finger_down (finger_down),
    .slot_free   (slot_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // Lanes are quiet whenever the sequencer is idle
  a_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (lane_busy == 2'b00))
    else $error("lane busy while sequencer idle");

  // A new result only ever comes from the emit state
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside emit");

  // Both lanes finished moves the sequencer on to emit
  a_div_to_emit: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) && (lane_busy == 2'b00)) |=> (state == ST_EMIT))
    else $error("sequencer missed lane completion");

endmodule
